// ----- src/avi_index_entry_router_core_defines.svh -----
// Assertion macros for the index entry router RTL.
`ifndef AVI_INDEX_ENTRY_ROUTER_CORE_DEFINES_SVH
`define AVI_INDEX_ENTRY_ROUTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define AVI_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define AVI_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/avi_ier_pkg.sv -----
// Types and constants for the AVI index entry router.
`timescale 1ns / 1ps
`default_nettype none

package avi_ier_pkg;

   typedef enum logic [1:0] {
      KIND_VIDEO   = 2'd0,
      KIND_AUDIO   = 2'd1,
      KIND_REC     = 2'd2,
      KIND_UNKNOWN = 2'd3
   } kind_type;

   // register indexes on the csr port
   localparam logic [1:0] CSR_MOVIE_OFFSET = 2'd0;
   localparam logic [1:0] CSR_REC_MODE     = 2'd1;
   localparam logic [1:0] CSR_TRACK_MASK   = 2'd2;

   localparam int MASK_W = 9;

   // fourcc upper halves and the rec list marker
   localparam logic [15:0] TYPE_DC  = 16'h6364;
   localparam logic [15:0] TYPE_DB  = 16'h6264;
   localparam logic [15:0] TYPE_WB  = 16'h6277;
   localparam logic [31:0] CODE_REC = 32'h2063_6572;

   localparam logic [31:0] KEY_FRAME   = 32'h0000_0010;
   localparam logic [7:0]  DIGIT_ZERO  = 8'h30;
   localparam logic [47:0] MOVI_HDR_ADJ = 48'd8;
   localparam logic [47:0] REC_HDR_ADJ  = 48'd12;

   typedef struct packed {
      kind_type    kind;
      logic        present;
      logic [3:0]  track;
      logic [31:0] flags;
      logic [31:0] offs;
      logic [31:0] len;
   } s1_type;

   typedef struct packed {
      logic [31:0] count;
      logic [47:0] total;
   } trk_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  track;
      logic [31:0] num;
      logic [47:0] abs_off;
      logic [31:0] size;
      logic [31:0] flags;
      logic [47:0] total;
      logic        err;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/avi_index_entry_router_core.sv -----
// AVI idx1 index entry router: classifies entries and places video/audio chunks.
`timescale 1ns / 1ps
`default_nettype none
//
// Usage
//  - req_* channel: one 16-byte idx1 entry per beat (fourcc, flags, offset,
//    length). A beat moves when req_valid is high and req_stall is low.
//  - rsp_* channel: exactly one result beat per entry, in entry order.
//    A beat moves when rsp_valid is high and rsp_stall is low.
//  - csr_* port: write movie offset, rec mode and track mask while idle.
//  - Pipeline: decode and track-table read at the accepting edge, then the
//    update stage loads the output register, which drives rsp_valid.
//  - Throughput: one entry per cycle unless the receiver stalls. Per-track
//    chunk counts and byte totals live in a small synchronous table (registered
//    read); an update-stage write to the entry read in the same cycle is forwarded.
//  - Reset (synchronous): clears config, counters, base offset, pipeline
//    valids and the per-entry valid bits of the track table; an entry never
//    written reads as zero, so no clearing pass is needed.
//  - Receiver stall: the output register holds its beat; the update stage
//    holds too, and req_stall rises only when that stage is also full.
//
module avi_index_entry_router_core #(
   parameter int MAX_AUDIO_TRACKS = 9
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration
   input  wire logic               csr_wr_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [47:0]        csr_wdata,
   // entry channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [31:0]        req_chunk_code,
   input  wire logic [31:0]        req_entry_flags,
   input  wire logic [31:0]        req_entry_offset,
   input  wire logic [31:0]        req_entry_length,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_entry_kind,
   output logic [3:0]              rsp_audio_track,
   output logic [31:0]             rsp_chunk_number,
   output logic signed [47:0]      rsp_absolute_offset,
   output logic [31:0]             rsp_chunk_size,
   output logic [31:0]             rsp_chunk_flags,
   output logic [47:0]             rsp_track_total_bytes,
   output logic                    rsp_track_error
);

   import avi_ier_pkg::*;

   `include "avi_index_entry_router_core_defines.svh"

   localparam int TrkIdxW = (MAX_AUDIO_TRACKS > 1) ? $clog2(MAX_AUDIO_TRACKS) : 1;

   // ---------------- configuration registers ----------------
   logic [47:0]       movie_ff;
   logic              rec_ff;
   logic [MASK_W-1:0] mask_ff;
   logic [47:0]       origin_ff;   // movie offset + 8 (+12 in rec mode)
   logic [47:0]       origin_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         movie_ff <= '0;
         rec_ff   <= 1'b0;
         mask_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MOVIE_OFFSET: movie_ff <= csr_wdata;
            CSR_REC_MODE:     rec_ff   <= csr_wdata[0];
            CSR_TRACK_MASK:   mask_ff  <= csr_wdata[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   assign origin_in = movie_ff + MOVI_HDR_ADJ + (rec_ff ? REC_HDR_ADJ : 48'd0);

   always_ff @(posedge clock) begin
      if (reset) origin_ff <= '0;
      else       origin_ff <= origin_in;
   end

   // ---------------- handshake ----------------
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic out_free;
   logic s1_fire;
   logic accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   // ---------------- stage 0: decode and table read ----------------
   logic [7:0]         digit_raw;
   logic [7:0]         digit;
   logic [TrkIdxW-1:0] req_idx;
   logic               req_present;
   logic [3:0]         req_track;
   kind_type           req_kind;

   always_comb begin
      digit_raw = req_chunk_code[15:8] - DIGIT_ZERO;
      // digits outside the track range fold onto track 0
      digit     = (digit_raw < 8'(MAX_AUDIO_TRACKS)) ? digit_raw : 8'd0;
      req_idx   = digit[TrkIdxW-1:0];
      req_present = (digit < 8'(MASK_W)) ? mask_ff[digit[3:0]] : 1'b0;
      // compacted track: present tracks below this digit
      req_track = 4'd0;
      for (int i = 0; i < MASK_W; i++) begin
         if (mask_ff[i] && (8'(i) < digit)) req_track = req_track + 4'd1;
      end
      if (req_chunk_code == CODE_REC) begin
         req_kind = KIND_REC;
      end else if (req_chunk_code[31:16] == TYPE_DC || req_chunk_code[31:16] == TYPE_DB) begin
         req_kind = KIND_VIDEO;
      end else if (req_chunk_code[31:16] == TYPE_WB) begin
         req_kind = KIND_AUDIO;
      end else begin
         req_kind = KIND_UNKNOWN;
      end
   end

   // ---------------- track table ----------------
   trk_type                     trk_mem [MAX_AUDIO_TRACKS];
   logic [MAX_AUDIO_TRACKS-1:0] trk_vld_ff;
   trk_type                     rd_data_ff;
   logic                        rd_vld_ff;
   logic                        byp_hit_ff;
   trk_type                     byp_data_ff;
   logic                        mem_we;
   logic [TrkIdxW-1:0]          mem_waddr;
   trk_type                     mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) trk_mem[mem_waddr] <= mem_wdata;
      if (accept) begin
         rd_data_ff  <= trk_mem[req_idx];
         byp_data_ff <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trk_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
         byp_hit_ff <= 1'b0;
      end else begin
         if (mem_we) trk_vld_ff[mem_waddr] <= 1'b1;
         if (accept) begin
            rd_vld_ff  <= trk_vld_ff[req_idx];
            // update stage writes the entry being read: take the new value
            byp_hit_ff <= mem_we && (mem_waddr == req_idx);
         end
      end
   end

   // ---------------- stage 1 register ----------------
   s1_type             s1_ff;
   logic [TrkIdxW-1:0] s1_idx_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff.kind    <= req_kind;
         s1_ff.present <= req_present;
         s1_ff.track   <= req_track;
         s1_ff.flags   <= req_entry_flags;
         s1_ff.offs    <= req_entry_offset;
         s1_ff.len     <= req_entry_length;
         s1_idx_ff     <= req_idx;
      end
   end

   // ---------------- stage 1: update ----------------
   logic [47:0] base_ff,  base_in;
   logic [31:0] video_ff, video_in;
   logic [31:0] audio_ff, audio_in;
   trk_type     trk_cur;
   logic        first;
   logic [47:0] offs48;
   rsp_type     rsp_in;
   rsp_type     rsp_ff;

   always_comb begin
      trk_cur = byp_hit_ff ? byp_data_ff : (rd_vld_ff ? rd_data_ff : '0);
      offs48  = {16'd0, s1_ff.offs};
      // no chunk placed yet: base reloads from this entry
      first   = (video_ff == 32'd0) && (audio_ff == 32'd0);

      base_in   = base_ff;
      video_in  = video_ff;
      audio_in  = audio_ff;
      mem_we    = 1'b0;
      mem_waddr = s1_idx_ff;
      mem_wdata.count = trk_cur.count + 32'd1;
      mem_wdata.total = trk_cur.total + {16'd0, s1_ff.len};

      rsp_in      = '0;
      rsp_in.kind = s1_ff.kind;

      if (s1_fire && first) base_in = origin_ff - offs48;

      case (s1_ff.kind)
         KIND_VIDEO: begin
            rsp_in.num     = video_ff;
            rsp_in.abs_off = first ? origin_ff : offs48 + base_ff;
            rsp_in.size    = s1_ff.len;
            rsp_in.flags   = (video_ff == 32'd0) ? KEY_FRAME : s1_ff.flags;
            if (s1_fire) video_in = video_ff + 32'd1;
         end
         KIND_AUDIO: begin
            rsp_in.abs_off = first ? origin_ff : offs48 + base_ff;
            rsp_in.size    = s1_ff.len;
            rsp_in.flags   = s1_ff.flags;
            if (s1_ff.present) begin
               rsp_in.track = s1_ff.track;
               rsp_in.num   = trk_cur.count;
               rsp_in.total = mem_wdata.total;
               if (s1_fire) begin
                  mem_we   = 1'b1;
                  audio_in = audio_ff + 32'd1;
               end
            end else begin
               rsp_in.err = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         video_ff     <= '0;
         audio_ff     <= '0;
      end else begin
         if (accept)       s1_valid_ff <= 1'b1;
         else if (s1_fire) s1_valid_ff <= 1'b0;
         if (out_free) rsp_valid_ff <= s1_fire;
         base_ff  <= base_in;
         video_ff <= video_in;
         audio_ff <= audio_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) rsp_ff <= rsp_in;
   end

   // ---------------- outputs ----------------
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_entry_kind        = rsp_ff.kind;
   assign rsp_audio_track       = rsp_ff.track;
   assign rsp_chunk_number      = rsp_ff.num;
   assign rsp_absolute_offset   = signed'(rsp_ff.abs_off);
   assign rsp_chunk_size        = rsp_ff.size;
   assign rsp_chunk_flags       = rsp_ff.flags;
   assign rsp_track_total_bytes = rsp_ff.total;
   assign rsp_track_error       = rsp_ff.err;

   // ---------------- assertions ----------------
   `AVI_ASSERT_IMP(a_stall_full, req_stall, s1_valid_ff && rsp_valid_ff,
      "req_stall without a full pipeline")
   `AVI_ASSERT_IMP(a_we_audio, mem_we,
      s1_fire && s1_ff.kind == KIND_AUDIO && s1_ff.present,
      "track table written by a non-audio or absent-track beat")
   `AVI_ASSERT_NXT(a_vld_set, mem_we, trk_vld_ff[$past(mem_waddr)],
      "track entry not marked valid after write")
   `AVI_ASSERT_NXT(a_video_cnt, s1_fire && s1_ff.kind == KIND_VIDEO,
      video_ff == 32'($past(video_ff) + 32'd1),
      "video chunk counter did not advance by one")

endmodule

`default_nettype wire

// ----- verif/avi_index_entry_router_core_tb.sv -----
// Testbench for the AVI idx1 index entry router core: random and directed entries, checked per beat.
`timescale 1ns / 1ps

// Tracks the router's placement state and queues the result beat each accepted entry should give.
class placement_scoreboard;
   localparam int TRACKS = 9;

   logic [47:0] movie_off;
   logic        rec_on;
   logic [8:0]  present;
   logic [47:0] base;
   logic [31:0] video_count;
   logic [31:0] audio_count;
   logic [31:0] trk_chunks [TRACKS];
   logic [47:0] trk_bytes [TRACKS];
   avi_ier_pkg::rsp_type placements_due [$];
   int errors;

   function new();
      movie_off   = '0;
      rec_on      = 1'b0;
      present     = '0;
      base        = '0;
      video_count = '0;
      audio_count = '0;
      errors      = 0;
      for (int i = 0; i < TRACKS; i++) begin
         trk_chunks[i] = '0;
         trk_bytes[i]  = '0;
      end
   endfunction

   function void write_reg(logic [1:0] idx, logic [47:0] data);
      case (idx)
         avi_ier_pkg::CSR_MOVIE_OFFSET: movie_off = data;
         avi_ier_pkg::CSR_REC_MODE:     rec_on    = data[0];
         avi_ier_pkg::CSR_TRACK_MASK:   present   = data[8:0];
         default: ;
      endcase
   endfunction

   function int pending_count();
      return placements_due.size();
   endfunction

   function void place_entry(logic [31:0] code, logic [31:0] flags,
                             logic [31:0] offs, logic [31:0] len);
      avi_ier_pkg::rsp_type want;
      logic [7:0] dbyte;
      int digit;
      want  = '0;
      dbyte = code[15:8];
      // digit bytes outside the track range fold onto track 0
      if (dbyte >= avi_ier_pkg::DIGIT_ZERO && dbyte < avi_ier_pkg::DIGIT_ZERO + 8'(TRACKS))
         digit = int'(dbyte - avi_ier_pkg::DIGIT_ZERO);
      else
         digit = 0;
      if (video_count == 0 && audio_count == 0) begin
         base = movie_off + avi_ier_pkg::MOVI_HDR_ADJ - {16'd0, offs};
         if (rec_on)
            base = base + avi_ier_pkg::REC_HDR_ADJ;
      end
      if (code == avi_ier_pkg::CODE_REC) begin
         want.kind = avi_ier_pkg::KIND_REC;
      end else if (code[31:16] == avi_ier_pkg::TYPE_DC || code[31:16] == avi_ier_pkg::TYPE_DB) begin
         want.kind    = avi_ier_pkg::KIND_VIDEO;
         want.num     = video_count;
         want.abs_off = {16'd0, offs} + base;
         want.size    = len;
         want.flags   = (video_count == 0) ? avi_ier_pkg::KEY_FRAME : flags;
         video_count  = video_count + 1;
      end else if (code[31:16] == avi_ier_pkg::TYPE_WB) begin
         want.kind    = avi_ier_pkg::KIND_AUDIO;
         want.abs_off = {16'd0, offs} + base;
         want.size    = len;
         want.flags   = flags;
         if (!present[digit]) begin
            want.err = 1'b1;
         end else begin
            for (int i = 0; i < digit; i++)
               if (present[i])
                  want.track = want.track + 4'd1;
            want.num          = trk_chunks[digit];
            trk_chunks[digit] = trk_chunks[digit] + 1;
            trk_bytes[digit]  = trk_bytes[digit] + {16'd0, len};
            want.total        = trk_bytes[digit];
            audio_count       = audio_count + 1;
         end
      end else begin
         want.kind = avi_ier_pkg::KIND_UNKNOWN;
      end
      placements_due.push_back(want);
   endfunction

   function void compare_field(string name, logic [47:0] want, logic [47:0] seen);
      if (want !== seen) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
         errors++;
      end
   endfunction

   function void check_placement(avi_ier_pkg::rsp_type seen);
      avi_ier_pkg::rsp_type want;
      if (placements_due.size() == 0) begin
         $error("result beat with no entry waiting");
         errors++;
         return;
      end
      want = placements_due.pop_front();
      compare_field("entry_kind", want.kind, seen.kind);
      compare_field("audio_track", want.track, seen.track);
      compare_field("chunk_number", want.num, seen.num);
      compare_field("absolute_offset", want.abs_off, seen.abs_off);
      compare_field("chunk_size", want.size, seen.size);
      compare_field("chunk_flags", want.flags, seen.flags);
      compare_field("track_total_bytes", want.total, seen.total);
      compare_field("track_error", want.err, seen.err);
   endfunction
endclass

module avi_index_entry_router_core_tb;
   import avi_ier_pkg::*;

   localparam int TRACKS       = 9;
   localparam int PHASE_ITEMS  = 375;  // five random phases, ~1900 entries in all
   localparam int HOLD_CYCLES  = 64;   // long receiver hold-off, well past pipeline depth
   localparam int DRAIN_CYCLES = 8;    // spare cycles after the last result beat
   localparam int IDLE_LIMIT   = 1000; // cycles without any beat before giving up

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [1:0]         csr_index;
   logic [47:0]        csr_wdata;
   logic               req_valid;
   logic               req_stall;
   logic [31:0]        req_chunk_code;
   logic [31:0]        req_entry_flags;
   logic [31:0]        req_entry_offset;
   logic [31:0]        req_entry_length;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_entry_kind;
   logic [3:0]         rsp_audio_track;
   logic [31:0]        rsp_chunk_number;
   logic signed [47:0] rsp_absolute_offset;
   logic [31:0]        rsp_chunk_size;
   logic [31:0]        rsp_chunk_flags;
   logic [47:0]        rsp_track_total_bytes;
   logic               rsp_track_error;

   placement_scoreboard sb;
   rsp_type             seen_beat;
   int                  quiet_cycles = 0;
   bit                  tx_gaps_on;    // sender inserts gap bursts
   bit                  rx_stalls_on;  // receiver inserts stall bursts
   bit                  hold_request;  // asks the receiver for one long hold-off
   bit                  moved;

   avi_index_entry_router_core #(
      .MAX_AUDIO_TRACKS(TRACKS)
   ) uut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_chunk_code        (req_chunk_code),
      .req_entry_flags       (req_entry_flags),
      .req_entry_offset      (req_entry_offset),
      .req_entry_length      (req_entry_length),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_entry_kind        (rsp_entry_kind),
      .rsp_audio_track       (rsp_audio_track),
      .rsp_chunk_number      (rsp_chunk_number),
      .rsp_absolute_offset   (rsp_absolute_offset),
      .rsp_chunk_size        (rsp_chunk_size),
      .rsp_chunk_flags       (rsp_chunk_flags),
      .rsp_track_total_bytes (rsp_track_total_bytes),
      .rsp_track_error       (rsp_track_error)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Monitor: everything is sampled right at the edge, before this edge's
   // nonblocking updates land, so it sees exactly what the block saw.
   always @(posedge clock) begin
      moved = 1'b0;
      if (!reset) begin
         if (csr_wr_en)
            sb.write_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall) begin
            sb.place_entry(req_chunk_code, req_entry_flags, req_entry_offset, req_entry_length);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            seen_beat.kind    = kind_type'(rsp_entry_kind);
            seen_beat.track   = rsp_audio_track;
            seen_beat.num     = rsp_chunk_number;
            seen_beat.abs_off = rsp_absolute_offset;
            seen_beat.size    = rsp_chunk_size;
            seen_beat.flags   = rsp_chunk_flags;
            seen_beat.total   = rsp_track_total_bytes;
            seen_beat.err     = rsp_track_error;
            sb.check_placement(seen_beat);
            moved = 1'b1;
         end
      end
      // watchdog: only counts cycles in which no beat moved on either side
      if (moved)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("[avi_index_entry_router_core] ERROR");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request so the
   // pipeline fills and pushes back on the entry side.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // One entry beat; returns at the edge that accepted it, valid left high.
   task automatic send_entry(input logic [31:0] code, input logic [31:0] flags,
                             input logic [31:0] offs, input logic [31:0] len);
      if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_chunk_code   <= code;
      req_entry_flags  <= flags;
      req_entry_offset <= offs;
      req_entry_length <= len;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
   endtask

   // Wait until every queued placement has come back, then let the pipe settle.
   task automatic drain();
      while (sb.pending_count() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers on back-to-back edges; only called when idle.
   task automatic program_regs(input logic [47:0] movie, input logic rec, input logic [8:0] mask);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MOVIE_OFFSET;
      csr_wdata <= movie;
      @(posedge clock);
      csr_index <= CSR_REC_MODE;
      csr_wdata <= {47'd0, rec};
      @(posedge clock);
      csr_index <= CSR_TRACK_MASK;
      csr_wdata <= {39'd0, mask};
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly well-formed video/audio fourccs with random low byte; some rec
   // markers, some garbage, and audio digits occasionally out of range.
   function automatic logic [31:0] random_code();
      int         pick;
      logic [7:0] dig;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0)
         dig = 8'($urandom);
      else
         dig = DIGIT_ZERO + 8'($urandom_range(0, TRACKS - 1));
      if (pick < 40)
         return {($urandom_range(0, 1) != 0) ? TYPE_DC : TYPE_DB, 8'($urandom), 8'($urandom)};
      else if (pick < 80)
         return {TYPE_WB, dig, 8'($urandom)};
      else if (pick < 88)
         return CODE_REC;
      return $urandom;
   endfunction

   // Random word with the all-zero and all-one extremes showing up often.
   function automatic logic [31:0] random_word();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick == 0)
         return 32'd0;
      else if (pick == 1)
         return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // hold_at: item index at which the receiver is asked for a long hold-off;
   // pause_at: item index at which the sender waits for all results. -1 = never.
   task automatic run_random(input int count, input int hold_at, input int pause_at);
      for (int k = 0; k < count; k++) begin
         if (k == hold_at)
            hold_request = 1'b1;
         if (k == pause_at) begin
            stop_sending();
            drain();
         end
         send_entry(random_code(), random_word(), random_word(), random_word());
      end
      stop_sending();
   endtask

   initial begin
      sb = new();
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_index        <= CSR_MOVIE_OFFSET;
      csr_wdata        <= '0;
      req_valid        <= 1'b0;
      req_chunk_code   <= '0;
      req_entry_flags  <= '0;
      req_entry_offset <= '0;
      req_entry_length <= '0;
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
      hold_request = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: max movie offset, rec mode on, tracks 1,2,4,6,8 present
      // (track 0 absent, so folded digits also hit the missing-track path).
      program_regs(48'hFFFF_FFFF_FFFF, 1'b1, 9'h156);
      // before any chunk is placed, each entry reloads the base
      send_entry(CODE_REC, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      send_entry(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_entry({TYPE_WB, DIGIT_ZERO, 8'h30}, 32'h0000_0001, 32'h0000_1234, 32'h0000_0040);
      send_entry({TYPE_WB, 8'h7A, 8'h30}, 32'h8000_0000, 32'h0000_0010, 32'h0000_0001);
      // first video chunk: key-frame flags, base frozen from here on
      send_entry({TYPE_DC, DIGIT_ZERO, 8'h30}, 32'hFFFF_FFFF, 32'h0000_0100, 32'hFFFF_FFFF);
      send_entry({TYPE_DB, DIGIT_ZERO, 8'h30}, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
      send_entry({TYPE_DC, DIGIT_ZERO + 8'd1, 8'h30}, 32'h5A5A_A5A5, 32'h8000_0000, 32'h1000);
      for (int d = 0; d < TRACKS; d++)
         send_entry({TYPE_WB, DIGIT_ZERO + 8'(d), 8'h30}, $urandom, $urandom, 32'hFFFF_FFFF);
      send_entry({TYPE_WB, DIGIT_ZERO + 8'd8, 8'h30}, 32'h0, 32'h0, 32'hFFFF_FFFF);
      // digit bytes outside '0'..'8' fold to track 0
      send_entry({TYPE_WB, 8'h00, 8'h30}, 32'h1, 32'h2, 32'h3);
      send_entry({TYPE_WB, 8'hFF, 8'h30}, 32'h4, 32'h5, 32'h6);
      send_entry({TYPE_WB, DIGIT_ZERO + 8'd9, 8'h30}, 32'h7, 32'h8, 32'h9);
      send_entry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_entry(CODE_REC, 32'h1234_5678, 32'h0000_0040, 32'h0000_0080);
      // one bit off the 'dc' type code: must come out unknown
      send_entry({TYPE_DC ^ 16'h0001, 8'h30, 8'h30}, 32'h1, 32'h1, 32'h1);
      stop_sending();
      drain();

      // all tracks present, so folded digits land on a live track 0
      program_regs(48'd0, 1'b0, 9'h1FF);
      run_random(PHASE_ITEMS, -1, -1);
      drain();

      // no track present: every audio beat flags an error
      program_regs({16'($urandom), 32'($urandom)}, 1'b1, 9'h000);
      run_random(PHASE_ITEMS, -1, -1);
      drain();

      // long receiver hold-off while entries keep coming
      program_regs({16'($urandom), 32'($urandom)}, 1'($urandom), 9'($urandom));
      run_random(PHASE_ITEMS, 100, -1);
      drain();

      // only track 0; sender stops mid-phase until every result is back
      program_regs(48'hFFFF_FFFF_FFFF, 1'b0, 9'h001);
      run_random(PHASE_ITEMS, -1, 150);
      drain();

      // closing stretch at full rate: no gaps, no stalls
      tx_gaps_on   = 1'b0;
      rx_stalls_on = 1'b0;
      program_regs(48'd0, 1'b1, 9'($urandom));
      run_random(PHASE_ITEMS, -1, -1);
      drain();

      if (sb.errors == 0 && sb.pending_count() == 0)
         $display("[avi_index_entry_router_core] OK");
      else
         $display("[avi_index_entry_router_core] ERROR");
      $finish;
   end

endmodule
